[src/joystick_motion_command_top_macros.svh]
// Assertion macros shared by the joystick motion command modules.
// Each user module must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef JOYSTICK_MOTION_COMMAND_TOP_MACROS_SVH
`define JOYSTICK_MOTION_COMMAND_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define JMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jmc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define JMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jmc assertion failed");

`else

`define JMC_ASSERT_NOW(lbl, ante, cons)
`define JMC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/jmc_pkg.sv]
// Shared types, constants and the arctangent table for the joystick motion command block.
// No dependencies; imported by every module of the block.
package jmc_pkg;

    // Field and register widths.
    localparam int FIELD_STICK_W = 11;
    localparam int DB_W          = 10;
    localparam int LIM_W         = 8;
    localparam int CFG_DATA_W    = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int FWD_W         = 11;
    localparam int SANG_W        = 13;
    localparam int TURN_W        = 9;
    localparam int HEAD_W        = 14;
    localparam int GAIT_W        = 4;

    // Register reset values and the legal range of the turn limit.
    localparam logic [DB_W-1:0]  FWD_DB_RST    = 10'd2;
    localparam logic [DB_W-1:0]  STR_DB_RST    = 10'd2;
    localparam logic [DB_W-1:0]  ROT_DB_RST    = 10'd20;
    localparam logic [LIM_W-1:0] ROT_LIMIT_RST = 8'd90;
    localparam logic [LIM_W-1:0] LIM_MIN       = 8'd1;
    localparam logic [LIM_W-1:0] LIM_MAX       = 8'd180;

    // CORDIC angle arithmetic, angles in 2^-16 degree.
    localparam int ATAN_LEN    = 20;
    localparam int ATAN_IW     = 5;
    localparam int ATAN_W      = 22;
    localparam int ZW          = 25;
    localparam int ANGLE_FRAC  = 16;
    localparam int ROUND_BIAS  = 2048;
    localparam int ROUND_SHIFT = 12;
    localparam int STRAFE_SAT  = 1440;

    // Division by 100 as a multiply by 5243 / 2^19, exact for magnitudes below 43690.
    localparam int               ROT_RECIP_W = 13;
    localparam logic [12:0]      ROT_RECIP   = 13'd5243;
    localparam int               ROT_SHIFT   = 19;

    typedef logic [ATAN_IW-1:0] t_atan_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_DB,
        CFG_STR_DB,
        CFG_ROT_DB,
        CFG_ROT_LIMIT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_ROUND,
        S_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic iter;
        logic round;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_step;
    } t_dp_sts;

    // atan(2^-i) in 2^-16 degree, rounded.
    function automatic logic [ATAN_W-1:0] atan_lut(input t_atan_idx idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/jmc_ctrl.sv]
// Controller state machine of the joystick motion command block.
// Depends on jmc_pkg and joystick_motion_command_top_macros.svh; drives jmc_dp commands.
`include "joystick_motion_command_top_macros.svh"

module jmc_ctrl import jmc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_accept;
    logic   out_free;

    // Handshake qualifiers.
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                if (i_sts.last_step) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = in_accept;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The result beat stays valid until it is taken; a commit refills it.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // An accepted beat always starts the CORDIC loop.
    `JMC_ASSERT_NEXT(a_accept_starts_iter, in_accept, r_state == S_ITER)
    // A finished item waits in commit while the output beat is still held.
    `JMC_ASSERT_NEXT(a_commit_waits, (r_state == S_COMMIT) && r_out_valid && i_out_stall,
                     r_state == S_COMMIT)
    // A commit always presents a result beat.
    `JMC_ASSERT_NEXT(a_commit_valid, o_cmd.commit, r_out_valid)

endmodule

[src/jmc_dp.sv]
// Datapath of the joystick motion command block: config registers, CORDIC atan2,
// rotation accumulator, gait selector and result registers. Depends on jmc_pkg and the macro header.
`include "joystick_motion_command_top_macros.svh"

module jmc_dp import jmc_pkg::*; #(
    parameter int STICK_BITS   = 11,
    parameter int CORDIC_STEPS = 14,
    parameter int GAIT_COUNT   = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [STICK_BITS-1:0] i_forward_stick,
    input  logic signed [STICK_BITS-1:0] i_strafe_stick,
    input  logic signed [STICK_BITS-1:0] i_rotate_stick,
    input  logic                         i_gait_button,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  t_dp_cmd                      i_cmd,
    output t_dp_sts                      o_sts,
    output logic signed [FWD_W-1:0]      o_forward_value,
    output logic                         o_move_ahead,
    output logic                         o_move_back,
    output logic signed [SANG_W-1:0]     o_strafe_angle,
    output logic                         o_strafe_active,
    output logic signed [TURN_W-1:0]     o_turn_angle,
    output logic                         o_turning,
    output logic signed [HEAD_W-1:0]     o_heading_angle,
    output logic [GAIT_W-1:0]            o_gait_index,
    output logic                         o_gait_changed
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int SW    = $clog2(NSTEP);
    localparam int EW    = ((STICK_BITS > FIELD_STICK_W) ? STICK_BITS : FIELD_STICK_W) + 1;
    localparam int CW    = STICK_BITS + ANGLE_FRAC + 3;
    localparam int PW    = EW + ROT_RECIP_W;
    localparam int QW    = PW - ROT_SHIFT;
    localparam int SUMW  = ((QW > TURN_W) ? QW : TURN_W) + 2;
    localparam int RW    = ZW - ROUND_SHIFT;
    localparam logic [SW-1:0] LAST_STEP = SW'(NSTEP - 1);

    // Configuration registers.
    logic [DB_W-1:0]  r_fwd_db;
    logic [DB_W-1:0]  r_str_db;
    logic [DB_W-1:0]  r_rot_db;
    logic [LIM_W-1:0] r_rot_lim;

    // Captured frame.
    logic signed [EW-1:0] r_fwd;
    logic signed [EW-1:0] r_str;
    logic signed [EW-1:0] r_rot;
    logic                 r_btn;

    // CORDIC registers.
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]        r_step;

    // Intermediate results from the rounding cycle.
    logic signed [SANG_W-1:0] r_sang;
    logic                     r_sact;
    logic [QW-1:0]            r_rot_q;
    logic                     r_rot_neg;

    // Persistent state.
    logic signed [TURN_W-1:0] r_accum;
    logic                     r_rot_flag;
    logic                     r_btn_held;
    logic [GAIT_W-1:0]        r_gait;
    logic signed [TURN_W-1:0] n_accum;
    logic                     n_rot_flag;
    logic                     n_btn_held;
    logic [GAIT_W-1:0]        n_gait;
    logic                     n_changed;

    // Result registers.
    logic signed [FWD_W-1:0]  r_o_fval;
    logic                     r_o_ahead;
    logic                     r_o_back;
    logic signed [SANG_W-1:0] r_o_sang;
    logic                     r_o_sact;
    logic signed [HEAD_W-1:0] r_o_head;
    logic                     r_o_changed;

    // Load values for the CORDIC vector.
    logic signed [CW-1:0] fwd_c;
    logic signed [CW-1:0] str_c;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;

    // One vectoring step.
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] atan_z;

    // Rounding and saturation.
    logic signed [ZW-1:0]     z_bias;
    logic signed [RW-1:0]     z_rnd;
    logic signed [SANG_W-1:0] sang_sat;

    // Deadband comparisons.
    logic signed [EW-1:0] fdb_e;
    logic signed [EW-1:0] sdb_e;
    logic signed [EW-1:0] rdb_e;
    logic                 fwd_pos;
    logic                 fwd_neg;
    logic                 str_act;
    logic                 rot_gt;
    logic                 rot_lt;

    // Rotation quotient and clamp.
    logic [EW-1:0]          rot_mag;
    logic [PW-1:0]          rot_prod;
    logic signed [SUMW-1:0] q_s;
    logic signed [SUMW-1:0] rot_sum;
    logic [LIM_W-1:0]       lim_c;
    logic [LIM_W-1:0]       lim_m1;
    logic signed [SUMW-1:0] lim_s;

    // Gait advance.
    logic [GAIT_W:0] gait_inc;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_db  <= FWD_DB_RST;
            r_str_db  <= STR_DB_RST;
            r_rot_db  <= ROT_DB_RST;
            r_rot_lim <= ROT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FWD_DB:    r_fwd_db  <= i_cfg_data[DB_W-1:0];
                CFG_STR_DB:    r_str_db  <= i_cfg_data[DB_W-1:0];
                CFG_ROT_DB:    r_rot_db  <= i_cfg_data[DB_W-1:0];
                CFG_ROT_LIMIT: r_rot_lim <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Vector setup: x = |forward|, y = strafe folded by the sign of forward.
    assign fwd_c = CW'(i_forward_stick);
    assign str_c = CW'(i_strafe_stick);
    assign x0    = (fwd_c < 0) ? ((-fwd_c) <<< ANGLE_FRAC) : (fwd_c <<< ANGLE_FRAC);
    assign y0    = (fwd_c < 0) ? ((-str_c) <<< ANGLE_FRAC) : (str_c <<< ANGLE_FRAC);

    // Shared shift-add unit, one step per cycle.
    assign dx     = r_y >>> r_step;
    assign dy     = r_x >>> r_step;
    assign atan_z = ZW'(signed'({1'b0, atan_lut(t_atan_idx'(r_step))}));

    assign o_sts.last_step = (r_step == LAST_STEP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fwd  <= EW'(i_forward_stick);
            r_str  <= EW'(i_strafe_stick);
            r_rot  <= EW'(i_rotate_stick);
            r_btn  <= i_gait_button;
            r_x    <= x0;
            r_y    <= y0;
            r_z    <= '0;
            r_step <= '0;
        end else if (i_cmd.iter) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_z;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_z;
            end
            r_step <= r_step + SW'(1);
        end
    end

    // Deadband thresholds as signed values.
    assign fdb_e = EW'({1'b0, r_fwd_db});
    assign sdb_e = EW'({1'b0, r_str_db});
    assign rdb_e = EW'({1'b0, r_rot_db});

    assign fwd_pos = (r_fwd > fdb_e);
    assign fwd_neg = (r_fwd < -fdb_e);
    assign str_act = (r_str > sdb_e) || (r_str < -sdb_e);
    assign rot_gt  = (r_rot > rdb_e) || (r_rot < -rdb_e);
    assign rot_lt  = (r_rot < rdb_e) && (r_rot > -rdb_e);

    // Round the angle to 1/16 degree and saturate.
    assign z_bias = r_z + ZW'(ROUND_BIAS);
    assign z_rnd  = RW'(z_bias >>> ROUND_SHIFT);
    always_comb begin
        if (z_rnd > RW'(STRAFE_SAT)) begin
            sang_sat = SANG_W'(STRAFE_SAT);
        end else if (z_rnd < RW'(-STRAFE_SAT)) begin
            sang_sat = SANG_W'(-STRAFE_SAT);
        end else begin
            sang_sat = SANG_W'(z_rnd);
        end
    end

    // Rotation magnitude divided by 100 through the reciprocal multiply.
    assign rot_mag  = (r_rot < 0) ? EW'(-r_rot) : EW'(r_rot);
    assign rot_prod = PW'(rot_mag) * PW'(ROT_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            r_sang    <= str_act ? sang_sat : '0;
            r_sact    <= str_act;
            r_rot_q   <= rot_prod[PW-1:ROT_SHIFT];
            r_rot_neg <= (r_rot < 0);
        end
    end

    // Turn accumulator with the limit forced into its legal range.
    always_comb begin
        if (r_rot_lim < LIM_MIN) begin
            lim_c = LIM_MIN;
        end else if (r_rot_lim > LIM_MAX) begin
            lim_c = LIM_MAX;
        end else begin
            lim_c = r_rot_lim;
        end
    end
    assign lim_m1  = lim_c - LIM_MIN;
    assign lim_s   = SUMW'({1'b0, lim_c});
    assign q_s     = SUMW'({1'b0, r_rot_q});
    assign rot_sum = SUMW'(r_accum) + (r_rot_neg ? -q_s : q_s);

    always_comb begin
        n_accum    = r_accum;
        n_rot_flag = r_rot_flag;
        if (rot_gt) begin
            n_rot_flag = 1'b1;
            if (rot_sum > lim_s) begin
                n_accum = TURN_W'({1'b0, lim_m1});
            end else if (rot_sum < -lim_s) begin
                n_accum = -TURN_W'({1'b0, lim_m1});
            end else begin
                n_accum = TURN_W'(rot_sum);
            end
        end else if (rot_lt) begin
            n_rot_flag = 1'b0;
        end
    end

    // Gait selection advances on a press, once per press.
    assign gait_inc = {1'b0, r_gait} + (GAIT_W + 1)'(1);
    always_comb begin
        n_gait     = r_gait;
        n_changed  = 1'b0;
        n_btn_held = r_btn;
        if (r_btn && !r_btn_held) begin
            n_changed = 1'b1;
            n_gait    = (gait_inc >= (GAIT_W + 1)'(GAIT_COUNT)) ? '0 : gait_inc[GAIT_W-1:0];
        end
    end

    // Persistent state updates once per item, at commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum    <= '0;
            r_rot_flag <= 1'b0;
            r_btn_held <= 1'b0;
            r_gait     <= '0;
        end else if (i_cmd.commit) begin
            r_accum    <= n_accum;
            r_rot_flag <= n_rot_flag;
            r_btn_held <= n_btn_held;
            r_gait     <= n_gait;
        end
    end

    // Result registers; the heading uses the turn angle from before this frame.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_fval    <= (fwd_pos || fwd_neg) ? FWD_W'(r_fwd) : '0;
            r_o_ahead   <= fwd_pos;
            r_o_back    <= fwd_neg;
            r_o_sang    <= r_sang;
            r_o_sact    <= r_sact;
            r_o_head    <= HEAD_W'(r_sang) + HEAD_W'(signed'({r_accum, 4'b0000}));
            r_o_changed <= n_changed;
        end
    end

    assign o_forward_value = r_o_fval;
    assign o_move_ahead    = r_o_ahead;
    assign o_move_back     = r_o_back;
    assign o_strafe_angle  = r_o_sang;
    assign o_strafe_active = r_o_sact;
    assign o_turn_angle    = r_accum;
    assign o_turning       = r_rot_flag;
    assign o_heading_angle = r_o_head;
    assign o_gait_index    = r_gait;
    assign o_gait_changed  = r_o_changed;

    // The turn angle never leaves the widest legal limit.
    `JMC_ASSERT_NOW(a_accum_range, 1'b1, (r_accum <= 9'sd180) && (r_accum >= -9'sd180))
    // The gait index always names an existing gait.
    `JMC_ASSERT_NOW(a_gait_range, 1'b1, {1'b0, r_gait} < (GAIT_W + 1)'(GAIT_COUNT))
    // Direction flags of a committed beat are exclusive.
    `JMC_ASSERT_NEXT(a_dir_exclusive, i_cmd.commit, !(r_o_ahead && r_o_back))
    // A committed beat that is not strafing carries a zero angle.
    `JMC_ASSERT_NEXT(a_strafe_zero, i_cmd.commit, r_o_sact || (r_o_sang == '0))

endmodule

[src/joystick_motion_command_top.sv]
// Top level of the joystick motion command block.
// Depends on jmc_pkg, jmc_ctrl and jmc_dp.

// One radio frame in, one walking command out. Each frame passes through these steps in
// order: capture of the frame; the atan2 steps (CORDIC_STEPS, counted as at most 20), one
// step per cycle in the single shared shift-add CORDIC unit; rounding of the angle and
// division of the rotation stick by 100; and the update of the turn and gait state with the
// load of the output register. The input stalls from capture until commit; a finished
// result beat waits in the output register while the next frame is accepted, and only the
// commit waits for it to be taken. Configuration writes take effect at once and are meant
// for idle periods.
module joystick_motion_command_top import jmc_pkg::*; #(
    parameter int GAIT_COUNT   = 4,
    parameter int STICK_BITS   = 11,
    parameter int CORDIC_STEPS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [STICK_BITS-1:0] i_forward_stick,
    input  logic signed [STICK_BITS-1:0] i_strafe_stick,
    input  logic signed [STICK_BITS-1:0] i_rotate_stick,
    input  logic                         i_gait_button,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [FWD_W-1:0]      o_forward_value,
    output logic                         o_move_ahead,
    output logic                         o_move_back,
    output logic signed [SANG_W-1:0]     o_strafe_angle,
    output logic                         o_strafe_active,
    output logic signed [TURN_W-1:0]     o_turn_angle,
    output logic                         o_turning,
    output logic signed [HEAD_W-1:0]     o_heading_angle,
    output logic [GAIT_W-1:0]            o_gait_index,
    output logic                         o_gait_changed
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer.
    jmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic, state and result registers.
    jmc_dp #(
        .STICK_BITS   (STICK_BITS),
        .CORDIC_STEPS (CORDIC_STEPS),
        .GAIT_COUNT   (GAIT_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_forward_stick (i_forward_stick),
        .i_strafe_stick  (i_strafe_stick),
        .i_rotate_stick  (i_rotate_stick),
        .i_gait_button   (i_gait_button),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .o_forward_value (o_forward_value),
        .o_move_ahead    (o_move_ahead),
        .o_move_back     (o_move_back),
        .o_strafe_angle  (o_strafe_angle),
        .o_strafe_active (o_strafe_active),
        .o_turn_angle    (o_turn_angle),
        .o_turning       (o_turning),
        .o_heading_angle (o_heading_angle),
        .o_gait_index    (o_gait_index),
        .o_gait_changed  (o_gait_changed)
    );

endmodule

[tb/sv/joystick_motion_command_top_test.sv]
// Self-checking testbench for joystick_motion_command_top: drives radio frames and register
// writes, predicts every walking command and checks each one field by field.
// Depends on jmc_pkg and the joystick_motion_command_top RTL.
`timescale 1ns / 100ps

import jmc_pkg::*;

// One radio frame as offered on the input channel.
typedef struct packed {
    logic signed [FIELD_STICK_W-1:0] forward;
    logic signed [FIELD_STICK_W-1:0] strafe;
    logic signed [FIELD_STICK_W-1:0] rotate;
    logic                            button;
} t_frame;

// One walking command as seen on the output channel.
typedef struct packed {
    logic signed [FWD_W-1:0]  forward_value;
    logic                     move_ahead;
    logic                     move_back;
    logic signed [SANG_W-1:0] strafe_angle;
    logic                     strafe_active;
    logic signed [TURN_W-1:0] turn_angle;
    logic                     turning;
    logic signed [HEAD_W-1:0] heading_angle;
    logic [GAIT_W-1:0]        gait_index;
    logic                     gait_changed;
} t_command;

// Mirrors the block's registers and turn/gait state, and holds the commands still owed.
class motion_scoreboard;
    localparam int NUM_GAITS    = 4;
    localparam int CORDIC_ITERS = 14;

    logic [DB_W-1:0]  fwd_db;
    logic [DB_W-1:0]  str_db;
    logic [DB_W-1:0]  rot_db;
    logic [LIM_W-1:0] turn_limit;
    int               turn_accum;
    bit               turn_flag;
    bit               button_down;
    int               gait;
    longint           atan_step[20];
    t_command         owed_q[$];
    int               mismatches;

    function new();
        fwd_db      = 10'd2;
        str_db      = 10'd2;
        rot_db      = 10'd20;
        turn_limit  = 8'd90;
        turn_accum  = 0;
        turn_flag   = 0;
        button_down = 0;
        gait        = 0;
        mismatches  = 0;
        // atan(2^-i) in 2^-16 degree.
        atan_step = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    endfunction

    function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FWD_DB:    fwd_db = data[DB_W-1:0];
            CFG_STR_DB:    str_db = data[DB_W-1:0];
            CFG_ROT_DB:    rot_db = data[DB_W-1:0];
            CFG_ROT_LIMIT: turn_limit = data[LIM_W-1:0];
            default: ;
        endcase
    endfunction

    function int outstanding();
        return owed_q.size();
    endfunction

    // Works out the command for an accepted frame and advances the turn and gait state.
    function void note_frame(t_frame fr);
        int       f, s, r, fdb, sdb, rdb, lim, sang;
        longint   x, y, z, dx, dy, rounded;
        t_command c;
        f   = $signed(fr.forward);
        s   = $signed(fr.strafe);
        r   = $signed(fr.rotate);
        fdb = fwd_db;
        sdb = str_db;
        rdb = rot_db;
        lim = turn_limit;
        c   = '0;

        // Forward deadband and exclusive direction flags.
        if (f > fdb) begin
            c.forward_value = FWD_W'(f);
            c.move_ahead    = 1'b1;
        end else if (f < -fdb) begin
            c.forward_value = FWD_W'(f);
            c.move_back     = 1'b1;
        end

        // Strafe direction by vectoring CORDIC, folded to the front half plane.
        sang = 0;
        if (s > sdb || s < -sdb) begin
            x = longint'(f < 0 ? -f : f) * 65536;
            y = longint'(f < 0 ? -s : s) * 65536;
            z = 0;
            for (int i = 0; i < CORDIC_ITERS && i < 20; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_step[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_step[i];
                end
            end
            rounded = (z + 2048) >>> 12;
            if (rounded > 1440) rounded = 1440;
            if (rounded < -1440) rounded = -1440;
            sang = int'(rounded);
            c.strafe_active = 1'b1;
        end
        c.strafe_angle  = SANG_W'(sang);
        c.heading_angle = HEAD_W'(sang + turn_accum * 16);

        // Rotation accumulates stick/100 and clamps just inside the limit.
        if (lim < 1) lim = 1;
        if (lim > 180) lim = 180;
        if (r > rdb || r < -rdb) begin
            turn_accum = turn_accum + r / 100;
            if (turn_accum > lim) turn_accum = lim - 1;
            if (turn_accum < -lim) turn_accum = -(lim - 1);
            turn_flag = 1;
        end else if (r < rdb && r > -rdb) begin
            turn_flag = 0;
        end
        c.turn_angle = TURN_W'(turn_accum);
        c.turning    = turn_flag;

        // Gait advances on a press, not while the button is held.
        if (fr.button && !button_down) begin
            c.gait_changed = 1'b1;
            gait = (gait + 1) % NUM_GAITS;
        end
        button_down  = fr.button;
        c.gait_index = GAIT_W'(gait);

        owed_q.push_back(c);
    endfunction

    function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function void check_command(t_command got);
        t_command want;
        if (owed_q.size() == 0) begin
            mismatches++;
            $error("command beat with no frame waiting");
            return;
        end
        want = owed_q.pop_front();
        check_field("forward_value", want.forward_value, got.forward_value);
        check_field("move_ahead", want.move_ahead, got.move_ahead);
        check_field("move_back", want.move_back, got.move_back);
        check_field("strafe_angle", want.strafe_angle, got.strafe_angle);
        check_field("strafe_active", want.strafe_active, got.strafe_active);
        check_field("turn_angle", want.turn_angle, got.turn_angle);
        check_field("turning", want.turning, got.turning);
        check_field("heading_angle", want.heading_angle, got.heading_angle);
        check_field("gait_index", want.gait_index, got.gait_index);
        check_field("gait_changed", want.gait_changed, got.gait_changed);
    endfunction
endclass

module joystick_motion_command_top_test;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int FRAMES_PER_STEP = 320;
    localparam int SETTLE_CYCLES   = 40;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic signed [FIELD_STICK_W-1:0] i_forward_stick;
    logic signed [FIELD_STICK_W-1:0] i_strafe_stick;
    logic signed [FIELD_STICK_W-1:0] i_rotate_stick;
    logic                            i_gait_button;
    logic                            i_cfg_we;
    logic [CFG_IDX_W-1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0]           i_cfg_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic signed [FWD_W-1:0]         o_forward_value;
    logic                            o_move_ahead;
    logic                            o_move_back;
    logic signed [SANG_W-1:0]        o_strafe_angle;
    logic                            o_strafe_active;
    logic signed [TURN_W-1:0]        o_turn_angle;
    logic                            o_turning;
    logic signed [HEAD_W-1:0]        o_heading_angle;
    logic [GAIT_W-1:0]               o_gait_index;
    logic                            o_gait_changed;

    motion_scoreboard sb;
    bit               calm;
    int               cycles;
    int               turn_dir;
    logic             btn_level;

    joystick_motion_command_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_forward_stick (i_forward_stick),
        .i_strafe_stick  (i_strafe_stick),
        .i_rotate_stick  (i_rotate_stick),
        .i_gait_button   (i_gait_button),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_forward_value (o_forward_value),
        .o_move_ahead    (o_move_ahead),
        .o_move_back     (o_move_back),
        .o_strafe_angle  (o_strafe_angle),
        .o_strafe_active (o_strafe_active),
        .o_turn_angle    (o_turn_angle),
        .o_turning       (o_turning),
        .o_heading_angle (o_heading_angle),
        .o_gait_index    (o_gait_index),
        .o_gait_changed  (o_gait_changed)
    );

    // 20 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stalls about a quarter of the cycles, except during the calm stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    // Monitor: note accepted frames and register writes, check accepted command beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_register(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_frame('{i_forward_stick, i_strafe_stick, i_rotate_stick,
                                i_gait_button});
            if (o_out_valid && !i_out_stall)
                sb.check_command('{o_forward_value, o_move_ahead, o_move_back,
                                   o_strafe_angle, o_strafe_active, o_turn_angle, o_turning,
                                   o_heading_angle, o_gait_index, o_gait_changed});
        end
    end

    // Offers one frame, sometimes after a random gap, and holds it until the beat is taken.
    // The gap is long enough that the block is often left waiting for a frame.
    task automatic send_frame(input logic [FIELD_STICK_W-1:0] fwd,
                              input logic [FIELD_STICK_W-1:0] str,
                              input logic [FIELD_STICK_W-1:0] rot,
                              input logic btn);
        if (!calm && $urandom_range(0, 99) < 25) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(8, 32)) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_forward_stick = fwd;
        i_strafe_stick  = str;
        i_rotate_stick  = rot;
        i_gait_button   = btn;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Holds off new frames until every command owed has come out.
    task automatic wait_all_commands();
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input int value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Stick value biased toward the extremes, zero and the edges of the deadband.
    function automatic logic [FIELD_STICK_W-1:0] pick_stick(input int db);
        int v;
        case ($urandom_range(0, 9))
            0: v = -1024;
            1: v = 1023;
            2, 3: begin
                v = db + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            4: v = 0;
            default: v = int'($urandom_range(0, 2047)) - 1024;
        endcase
        return v[FIELD_STICK_W-1:0];
    endfunction

    // Random frame; the rotation stick runs in streaks so the turn angle reaches its clamp.
    task automatic send_random_frame();
        int rot;
        if ($urandom_range(0, 19) == 0) turn_dir = -turn_dir;
        if ($urandom_range(0, 1))
            rot = turn_dir * int'($urandom_range(100, 1023));
        else
            rot = $signed(pick_stick(sb.rot_db));
        if ($urandom_range(0, 2) == 0) btn_level = ~btn_level;
        send_frame(pick_stick(sb.fwd_db), pick_stick(sb.str_db), rot[FIELD_STICK_W-1:0],
                   btn_level);
    endtask

    // Register settings per step: zero deadbands with a limit below range, all ones,
    // a mixed set, a random set, and a tight limit.
    int step_cfg[6][4] = '{
        '{2, 2, 20, 90},
        '{0, 0, 0, 0},
        '{1023, 1023, 1023, 255},
        '{3, 100, 0, 180},
        '{0, 0, 0, 0},
        '{2, 2, 20, 10}
    };

    initial begin
        sb              = new();
        cycles          = 0;
        calm            = 1'b0;
        turn_dir        = 1;
        btn_level       = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_forward_stick = '0;
        i_strafe_stick  = '0;
        i_rotate_stick  = '0;
        i_gait_button   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_out_stall     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames at the reset settings: deadband edges, stick extremes,
        // backward fold of the strafe angle, rotation exactly at its deadband, gait wrap.
        send_frame(0, 0, 0, 0);
        send_frame(1023, 0, 21, 1);
        send_frame(-1024, 1023, 20, 1);
        send_frame(2, -1024, -20, 0);
        send_frame(3, 3, 1023, 1);
        send_frame(-2, 2, 19, 0);
        send_frame(-3, -3, -1024, 1);
        send_frame(0, 1023, -21, 0);
        send_frame(0, -1024, 99, 1);
        send_frame(-1024, -1024, -99, 1);
        send_frame(1023, 1023, 1023, 0);
        send_frame(-500, 300, -150, 0);
        // Keep turning one way until the turn angle clamps.
        for (int k = 0; k < 10; k++)
            send_frame(pick_stick(2), pick_stick(2), 1023, k[0]);

        for (int st = 0; st < 6; st++) begin
            if (st > 0) begin
                wait_all_commands();
                for (int k = 0; k < 4; k++)
                    write_register(t_cfg_idx'(k),
                                   st == 4 ? int'($urandom_range(0, k == 3 ? 255 : 1023))
                                           : step_cfg[st][k]);
            end
            calm = (st == 3);
            for (int n = 0; n < FRAMES_PER_STEP; n++) begin
                if (st == 3 && n == FRAMES_PER_STEP / 2) begin
                    calm = 1'b0;
                    wait_all_commands();
                end
                send_random_frame();
            end
        end

        wait_all_commands();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[joystick_motion_command_top.f]
+incdir+src
src/jmc_pkg.sv
src/jmc_ctrl.sv
src/jmc_dp.sv
src/joystick_motion_command_top.sv
tb/sv/joystick_motion_command_top_test.sv
